@@ design/sid_pkg.sv @@
// ----------------------------------------------------------------------------
// sid_pkg
// shared constants and types for the signed integer divider
// ----------------------------------------------------------------------------
package sid_pkg;

  // default operand width
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // status from the shift-subtract core to the control
  typedef struct packed {
    logic busy;  // iteration in progress
    logic last;  // final quotient bit is produced this cycle
  } core_stat_t;

endpackage

@@ design/sid_divcore.sv @@
// ----------------------------------------------------------------------------
// sid_divcore
// restoring shift-subtract core on magnitudes, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sid_divcore #(
  parameter int unsigned DATA_WIDTH = sid_pkg::DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [DATA_WIDTH-1:0]  num,
  input  logic [DATA_WIDTH-1:0]  den,
  output logic [DATA_WIDTH-1:0]  quo,
  output sid_pkg::core_stat_t    stat
);

  localparam int unsigned CNT_W = $clog2(DATA_WIDTH + 1);

  logic [DATA_WIDTH-1:0] num_r, num_nxt;
  logic [DATA_WIDTH-1:0] den_r;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;

  logic [DATA_WIDTH-1:0] trial;
  logic [DATA_WIDTH:0]   diff;
  logic                  fits;

  // remainder stays below the divisor magnitude, so its top bit is always clear
  assign trial = {rem_r[DATA_WIDTH-2:0], num_r[DATA_WIDTH-1]};
  assign diff  = {1'b0, trial} - {1'b0, den_r};
  assign fits  = ~diff[DATA_WIDTH];

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      num_nxt  = num;
      rem_nxt  = '0;
      quo_nxt  = '0;
      cnt_nxt  = CNT_W'(DATA_WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt  = {num_r[DATA_WIDTH-2:0], 1'b0};
      rem_nxt  = fits ? diff[DATA_WIDTH-1:0] : trial;
      quo_nxt  = {quo_r[DATA_WIDTH-2:0], fits};
      cnt_nxt  = cnt_r - CNT_W'(1);
      busy_nxt = (cnt_r != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign quo       = quo_r;
  assign stat.busy = busy_r;
  assign stat.last = busy_r && (cnt_r == CNT_W'(1));

endmodule

@@ design/signed_int32_divider_core.sv @@
// ----------------------------------------------------------------------------
// signed_int32_divider_core
// signed integer divider, quotient truncated toward zero
// ----------------------------------------------------------------------------
// one word in, one word out. the quotient is dividend / divisor truncated
// toward zero. the most negative value divided by minus one gives the largest
// positive value with out_saturated set. a zero divisor gives quotient 0 with
// out_divide_by_zero set. operand magnitudes are formed as the word is
// accepted, the restoring shift-subtract loop in S_RUN yields one quotient
// bit per cycle, and S_FIN applies the sign as it loads the output register.
// in_ready comes back in the cycle out_valid rises, so a new word can be
// accepted only once the last one has reached the output register. a zero
// divisor skips the loop and goes from accept straight to S_FIN. one word is
// in flight at a time; the output register lets the next word be accepted
// while a result still waits, and a finished word waits for that register
// to free.
// ----------------------------------------------------------------------------
module signed_int32_divider_core #(
  parameter int unsigned DATA_WIDTH = sid_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [DATA_WIDTH-1:0]  in_dividend,
  input  logic signed [DATA_WIDTH-1:0]  in_divisor,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [DATA_WIDTH-1:0]  out_quotient,
  output logic                          out_saturated,
  output logic                          out_divide_by_zero
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN
  } state_t;

  state_t                 state_r;
  logic                   q_neg_r;
  logic                   dz_r;
  logic                   out_valid_r;
  logic [DATA_WIDTH-1:0]  out_quotient_r;
  logic                   out_saturated_r;
  logic                   out_dz_r;

  // operand magnitudes at entry
  logic [DATA_WIDTH-1:0]  a_bits, b_bits, a_mag, b_mag;
  logic                   a_neg, b_neg, b_zero;
  logic                   start;

  // result shaping at exit
  logic [DATA_WIDTH-1:0]  core_quo;
  logic [DATA_WIDTH-1:0]  q_signed;
  logic                   q_sat;
  logic                   out_free;
  logic                   fin_load;
  sid_pkg::core_stat_t    stat;

  localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  assign a_bits = in_dividend;
  assign b_bits = in_divisor;
  assign a_neg  = a_bits[DATA_WIDTH-1];
  assign b_neg  = b_bits[DATA_WIDTH-1];
  assign b_zero = (b_bits == '0);
  // the most negative value maps to 2^(DATA_WIDTH-1) read as unsigned
  assign a_mag  = a_neg ? (~a_bits + DATA_WIDTH'(1)) : a_bits;
  assign b_mag  = b_neg ? (~b_bits + DATA_WIDTH'(1)) : b_bits;

  assign in_ready = (state_r == S_IDLE);
  assign start    = in_valid && in_ready && !b_zero;

  sid_divcore #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_divcore (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .num   (a_mag),
    .den   (b_mag),
    .quo   (core_quo),
    .stat  (stat)
  );

  // a positive quotient with the top bit set only comes from min / -1
  assign q_signed = q_neg_r ? (~core_quo + DATA_WIDTH'(1)) : core_quo;
  assign q_sat    = !q_neg_r && core_quo[DATA_WIDTH-1];
  assign out_free = !out_valid_r || out_ready;
  // finished word moves into the output register
  assign fin_load = (state_r == S_FIN) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            q_neg_r <= a_neg ^ b_neg;
            dz_r    <= b_zero;
            state_r <= b_zero ? S_FIN : S_RUN;
          end
        end
        S_RUN: begin
          if (stat.last) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          // hold the finished word until the output register is free
          if (out_free) begin
            if (dz_r) begin
              out_quotient_r  <= '0;
              out_saturated_r <= 1'b0;
              out_dz_r        <= 1'b1;
            end else begin
              out_quotient_r  <= q_sat ? MAX_POS : q_signed;
              out_saturated_r <= q_sat;
              out_dz_r        <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_quotient       = out_quotient_r;
  assign out_saturated      = out_saturated_r;
  assign out_divide_by_zero = out_dz_r;

`ifndef SYNTHESIS
  // the loop only runs while the control waits on it
  a_core_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> (state_r == S_RUN))
    else $error("divider loop busy outside run state");

  // no new word is taken while the loop works
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> !in_ready)
    else $error("input accepted while divider busy");

  // the two flags never appear together
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_saturated && out_divide_by_zero))
    else $error("saturated and divide-by-zero both set");

  // zero divisor gives a zero quotient
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divide_by_zero) |-> (out_quotient == '0))
    else $error("divide-by-zero word with nonzero quotient");
`endif

endmodule
